// ===== hdl/utf8le_pkg.sv =====
// ----------------------------------------------------------------------------
// utf8le_pkg
// Shared types, codes and escape-string tables for the UTF-8 checked LaTeX
// escaper.
// ----------------------------------------------------------------------------
`default_nettype none

package utf8le_pkg;

  // Sequence phase codes
  localparam logic [1:0] PH_IDLE         = 2'd0;
  localparam logic [1:0] PH_TWO_FINAL    = 2'd1;
  localparam logic [1:0] PH_THREE_SECOND = 2'd2;
  localparam logic [1:0] PH_THREE_THIRD  = 2'd3;

  // Job kinds: what the expander emits for one accepted byte
  localparam logic [1:0] JOB_BYTES     = 2'd0;  // up to three literal bytes
  localparam logic [1:0] JOB_BACKSLASH = 2'd1;  // twelve bytes $\backslash$
  localparam logic [1:0] JOB_EURO      = 2'd2;  // five bytes \euro
  localparam logic [1:0] JOB_BAD       = 2'd3;  // one bad-lead result

  localparam logic [3:0] BACKSLASH_LEN = 4'd12;
  localparam logic [3:0] EURO_LEN      = 4'd5;

  localparam logic [15:0] EURO_CP = 16'h20AC;

  typedef struct packed {
    logic [1:0]      kind;
    logic [3:0]      len;
    logic [2:0][7:0] bytes;
  } job_t;

  function automatic logic [7:0] backslash_char(input logic [3:0] idx);
    logic [7:0] c;
    unique case (idx)
      4'd0:    c = 8'h24;  // $
      4'd1:    c = 8'h5C;  // backslash
      4'd2:    c = 8'h62;  // b
      4'd3:    c = 8'h61;  // a
      4'd4:    c = 8'h63;  // c
      4'd5:    c = 8'h6B;  // k
      4'd6:    c = 8'h73;  // s
      4'd7:    c = 8'h6C;  // l
      4'd8:    c = 8'h61;  // a
      4'd9:    c = 8'h73;  // s
      4'd10:   c = 8'h68;  // h
      4'd11:   c = 8'h24;  // $
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  function automatic logic [7:0] euro_char(input logic [2:0] idx);
    logic [7:0] c;
    unique case (idx)
      3'd0:    c = 8'h5C;  // backslash
      3'd1:    c = 8'h65;  // e
      3'd2:    c = 8'h75;  // u
      3'd3:    c = 8'h72;  // r
      3'd4:    c = 8'h6F;  // o
      default: c = 8'h00;
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

// ===== hdl/utf8_checked_latex_escaper.sv =====
// ----------------------------------------------------------------------------
// utf8_checked_latex_escaper
// Byte stream filter: checks two- and three-byte UTF-8 sequences and escapes
// text for LaTeX.
// ----------------------------------------------------------------------------
// Usage:
//   Slave channel s_* carries one raw text byte per transfer; a zero byte ends
//   the text and drops any pending UTF-8 sequence. Master channel m_* carries
//   the results: m_tdata is the output byte, m_tuser flags it (has_byte,
//   bad_lead) and m_tlast marks the last result caused by one input byte.
//   A byte that produces no result (zero, held lead or second byte, bad
//   continuation) still takes its transfer but sends nothing.
// Flow:
//   A byte's results pass from the job register through the result register
//   to m_*, one result per cycle while m_tready allows. A byte with N results
//   holds the input side until its last result is emitted (N is 1..12: twelve
//   for a backslash, five for the euro sign), so plain text moves at one byte
//   per cycle without stalls, a rate set by the single job register.
// Reset:
//   rst (synchronous, active high) empties the job and result registers and
//   returns the UTF-8 decoder to idle.
// Stall:
//   While m_tvalid is high and m_tready is low the result register holds, the job
//   register holds its position and s_tready drops once the current job cannot finish.
// ----------------------------------------------------------------------------
`default_nettype none

module utf8_checked_latex_escaper
  import utf8le_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       s_tvalid,
  output logic            s_tready,
  input  wire logic [7:0] s_tdata,   // [7:0] text_byte
  output logic            m_tvalid,
  input  wire logic       m_tready,
  output logic [7:0]      m_tdata,   // [7:0] out_byte
  output logic [1:0]      m_tuser,   // [0] has_byte, [1] bad_lead
  output logic            m_tlast    // run_last
);

  // Decoder state
  logic [1:0] phase, phase_next;
  logic [7:0] held_lead, held_lead_next;
  logic [7:0] held_second, held_second_next;

  // Job register: one accepted byte worth of pending results
  logic       job_valid;
  job_t       job;
  logic [3:0] idx;

  // Decoded job for the byte on s_tdata
  job_t       new_job;
  logic       new_load;

  logic       s_xfer;
  logic       emit;
  logic       job_last;
  logic       is_cont;
  logic [15:0] cp;

  logic [7:0] emit_byte;
  logic       emit_has;
  logic       emit_bad;

  assign s_xfer   = s_tvalid && s_tready;
  assign emit     = job_valid && (!m_tvalid || m_tready);
  assign job_last = (idx == job.len - 4'd1);
  // Take a new byte when the job register is free or empties this cycle
  assign s_tready = !job_valid || (emit && job_last);

  assign is_cont = (s_tdata[7:6] == 2'b10);
  assign cp      = {held_lead[3:0], held_second[5:0], s_tdata[5:0]};

  // Decode the incoming byte against the current phase
  always_comb begin
    phase_next       = phase;
    held_lead_next   = held_lead;
    held_second_next = held_second;
    new_load         = 1'b0;
    new_job.kind     = JOB_BYTES;
    new_job.len      = 4'd1;
    new_job.bytes    = '0;
    if (s_tdata == 8'h00) begin
      phase_next = PH_IDLE;
    end else begin
      unique case (phase)
        PH_IDLE: begin
          priority if (s_tdata < 8'h20) begin
            new_load         = 1'b1;
            new_job.bytes[0] = 8'h3F;  // '?'
          end else if (s_tdata <= 8'h7F) begin
            new_load = 1'b1;
            priority if (s_tdata == 8'h24 || s_tdata == 8'h26 || s_tdata == 8'h7C) begin
              new_job.len      = 4'd2;
              new_job.bytes[0] = 8'h5C;
              new_job.bytes[1] = s_tdata;
            end else if (s_tdata == 8'h5C) begin
              new_job.kind = JOB_BACKSLASH;
              new_job.len  = BACKSLASH_LEN;
            end else begin
              new_job.bytes[0] = s_tdata;
            end
          end else if ((s_tdata & 8'hE0) == 8'hC0) begin
            held_lead_next = s_tdata;
            phase_next     = PH_TWO_FINAL;
          end else if ((s_tdata & 8'hF0) == 8'hE0) begin
            held_lead_next = s_tdata;
            phase_next     = PH_THREE_SECOND;
          end else begin
            new_load     = 1'b1;
            new_job.kind = JOB_BAD;
          end
        end
        PH_TWO_FINAL: begin
          phase_next = PH_IDLE;
          if (is_cont) begin
            new_load         = 1'b1;
            new_job.len      = 4'd2;
            new_job.bytes[0] = held_lead;
            new_job.bytes[1] = s_tdata;
          end
        end
        PH_THREE_SECOND: begin
          if (is_cont) begin
            held_second_next = s_tdata;
            phase_next       = PH_THREE_THIRD;
          end else begin
            phase_next = PH_IDLE;
          end
        end
        PH_THREE_THIRD: begin
          phase_next = PH_IDLE;
          if (is_cont) begin
            new_load = 1'b1;
            if (cp == EURO_CP) begin
              new_job.kind = JOB_EURO;
              new_job.len  = EURO_LEN;
            end else begin
              new_job.len      = 4'd3;
              new_job.bytes[0] = held_lead;
              new_job.bytes[1] = held_second;
              new_job.bytes[2] = s_tdata;
            end
          end
        end
        default: phase_next = PH_IDLE;
      endcase
    end
  end

  // Pick the result at the current job position
  always_comb begin
    emit_has  = 1'b1;
    emit_bad  = 1'b0;
    emit_byte = 8'h00;
    unique case (job.kind)
      JOB_BYTES:     emit_byte = job.bytes[idx[1:0]];
      JOB_BACKSLASH: emit_byte = backslash_char(idx);
      JOB_EURO:      emit_byte = euro_char(idx[2:0]);
      JOB_BAD: begin
        emit_has = 1'b0;
        emit_bad = 1'b1;
      end
      default: emit_byte = 8'h00;
    endcase
  end

  // Decoder state and job register
  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_IDLE;
      held_lead   <= 8'h00;
      held_second <= 8'h00;
      job_valid   <= 1'b0;
      idx         <= 4'd0;
    end else begin
      if (s_xfer) begin
        phase       <= phase_next;
        held_lead   <= held_lead_next;
        held_second <= held_second_next;
      end
      if (emit && !job_last) begin
        idx <= idx + 4'd1;
      end else if (s_xfer) begin
        // job register free or finishing: load the next job, if any
        job_valid <= new_load;
        idx       <= 4'd0;
      end else if (emit) begin
        job_valid <= 1'b0;
        idx       <= 4'd0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s_xfer) begin
      job <= new_job;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (emit) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      m_tdata <= emit_byte;
      m_tuser <= {emit_bad, emit_has};
      m_tlast <= job_last;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/utf8le_checker.sv =====
// ----------------------------------------------------------------------------
// utf8le_props
// Port-level checks on the escaper's result channel, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module utf8le_props (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       s_tready,
  input wire logic       m_tvalid,
  input wire logic       m_tready,
  input wire logic [7:0] m_tdata,
  input wire logic [1:0] m_tuser,
  input wire logic       m_tlast
);

  // A stalled result holds its payload
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
      && $stable(m_tlast))
    else $error("stalled result changed");

  // Reset empties the result register and opens the input
  a_reset: assert property (@(posedge clk) rst |=> !m_tvalid && s_tready)
    else $error("result valid or input closed after reset");

  // A bad-lead report carries no byte and ends its run
  a_bad: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[1] |-> !m_tuser[0] && m_tdata == 8'h00 && m_tlast)
    else $error("malformed bad-lead result");

  // Every result carries either a byte or a bad-lead report
  a_kind: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tuser[0] != m_tuser[1]))
    else $error("result with neither byte nor report");

  // No result carries a byte below 0x20; control bytes from idle come out as question marks
  a_ctrl: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[0] |-> m_tdata >= 8'h20)
    else $error("control byte passed through");

endmodule

bind utf8_checked_latex_escaper utf8le_props u_props (
  .clk      (clk),
  .rst      (rst),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser),
  .m_tlast  (m_tlast)
);

`default_nettype wire

// ===== bench/utf8le_checker.sv =====
// ----------------------------------------------------------------------------
// utf8le_checker
// Watches both stream channels of the UTF-8 checked LaTeX escaper, predicts
// the escaped output of every accepted text byte and compares each accepted
// result against the oldest prediction, field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module utf8le_checker
  import utf8le_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       s_tvalid,
  input  wire logic       s_tready,
  input  wire logic [7:0] s_tdata,    // [7:0] text_byte
  input  wire logic       m_tvalid,
  input  wire logic       m_tready,
  input  wire logic [7:0] m_tdata,    // [7:0] out_byte
  input  wire logic [1:0] m_tuser,    // [0] has_byte, [1] bad_lead
  input  wire logic       m_tlast,    // run_last
  output int              errors,
  output int              outstanding
);

  localparam logic [7:0] CH_QUESTION  = 8'h3F;
  localparam logic [7:0] CH_DOLLAR    = 8'h24;
  localparam logic [7:0] CH_AMP       = 8'h26;
  localparam logic [7:0] CH_BAR       = 8'h7C;
  localparam logic [7:0] CH_BACKSLASH = 8'h5C;
  localparam logic [7:0] CH_SPACE     = 8'h20;
  localparam logic [7:0] CH_DEL       = 8'h7F;

  // First character sits in the top byte of each literal
  localparam logic [95:0] BACKSLASH_TEXT = "$\\backslash$";
  localparam logic [39:0] EURO_TEXT      = "\\euro";

  typedef struct packed {
    logic [7:0] ch;
    logic       has;
    logic       bad;
    logic       last;
  } esc_out_t;

  esc_out_t   escaped_fifo[$];
  logic [1:0] seq_phase;
  logic [7:0] held_lead;
  logic [7:0] held_second;

  task automatic push_char(input logic [7:0] ch, input logic has, input logic bad);
    esc_out_t r;
    r.ch   = has ? ch : 8'h00;
    r.has  = has;
    r.bad  = bad;
    r.last = 1'b0;
    escaped_fifo.push_back(r);
  endtask

  // Advance the decoder by one text byte and queue what it should emit
  task automatic escape_text_byte(input logic [7:0] b);
    int         n;
    int         i;
    logic [15:0] cp;
    esc_out_t   tail;
    n = 0;
    if (b == 8'h00) begin
      seq_phase = PH_IDLE;
    end else begin
      case (seq_phase)
        PH_IDLE: begin
          if (b < CH_SPACE) begin
            push_char(CH_QUESTION, 1'b1, 1'b0);
            n = 1;
          end else if (b <= CH_DEL) begin
            if (b == CH_DOLLAR || b == CH_AMP || b == CH_BAR) begin
              push_char(CH_BACKSLASH, 1'b1, 1'b0);
              push_char(b, 1'b1, 1'b0);
              n = 2;
            end else if (b == CH_BACKSLASH) begin
              for (i = 0; i < 12; i++)
                push_char(BACKSLASH_TEXT[8*(11-i) +: 8], 1'b1, 1'b0);
              n = 12;
            end else begin
              push_char(b, 1'b1, 1'b0);
              n = 1;
            end
          end else if (b[7:5] == 3'b110) begin
            held_lead = b;
            seq_phase = PH_TWO_FINAL;
          end else if (b[7:4] == 4'b1110) begin
            held_lead = b;
            seq_phase = PH_THREE_SECOND;
          end else begin
            push_char(8'h00, 1'b0, 1'b1);
            n = 1;
          end
        end
        PH_TWO_FINAL: begin
          seq_phase = PH_IDLE;
          if (b[7:6] == 2'b10) begin
            push_char(held_lead, 1'b1, 1'b0);
            push_char(b, 1'b1, 1'b0);
            n = 2;
          end
        end
        PH_THREE_SECOND: begin
          if (b[7:6] == 2'b10) begin
            held_second = b;
            seq_phase = PH_THREE_THIRD;
          end else begin
            seq_phase = PH_IDLE;
          end
        end
        default: begin
          seq_phase = PH_IDLE;
          if (b[7:6] == 2'b10) begin
            cp = {held_lead[3:0], held_second[5:0], b[5:0]};
            if (cp == EURO_CP) begin
              for (i = 0; i < 5; i++)
                push_char(EURO_TEXT[8*(4-i) +: 8], 1'b1, 1'b0);
              n = 5;
            end else begin
              push_char(held_lead, 1'b1, 1'b0);
              push_char(held_second, 1'b1, 1'b0);
              push_char(b, 1'b1, 1'b0);
              n = 3;
            end
          end
        end
      endcase
    end
    // Flag the final result of this byte
    if (n > 0) begin
      tail = escaped_fifo[escaped_fifo.size() - 1];
      tail.last = 1'b1;
      escaped_fifo[escaped_fifo.size() - 1] = tail;
    end
  endtask

  task automatic report_field(input string field, input logic [7:0] want,
                              input logic [7:0] got);
    $display("%0t: %s mismatch: expected 0x%02h, actual 0x%02h",
             $time, field, want, got);
    errors++;
  endtask

  task automatic check_result();
    esc_out_t want;
    if (escaped_fifo.size() == 0) begin
      $display("%0t: unexpected result: expected none, actual byte 0x%02h user %b last %b",
               $time, m_tdata, m_tuser, m_tlast);
      errors++;
    end else begin
      want = escaped_fifo.pop_front();
      if (m_tdata !== want.ch)     report_field("out_byte", want.ch, m_tdata);
      if (m_tuser[0] !== want.has) report_field("has_byte", want.has, m_tuser[0]);
      if (m_tuser[1] !== want.bad) report_field("bad_lead", want.bad, m_tuser[1]);
      if (m_tlast !== want.last)   report_field("run_last", want.last, m_tlast);
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      seq_phase   = PH_IDLE;
      held_lead   = 8'h00;
      held_second = 8'h00;
      errors      = 0;
      escaped_fifo.delete();
      outstanding <= 0;
    end else begin
      if (m_tvalid && m_tready)
        check_result();
      if (s_tvalid && s_tready)
        escape_text_byte(s_tdata);
      outstanding <= escaped_fifo.size();
    end
  end

endmodule

// ===== bench/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Drives text bytes into the UTF-8 checked LaTeX escaper under changing idle
// patterns on both channels, with a long output hold-off and drain pauses;
// the checker predicts and compares, this module gives the verdict.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;
  import utf8le_pkg::*;

  localparam int QUIET_LIMIT    = 3000;  // cycles with no transfer on either side
  localparam int ITEMS_PER_STEP = 140;
  localparam int HOLD_CYCLES    = 200;
  localparam int HOLD_BURST     = 40;

  localparam logic [7:0] CH_DOLLAR    = 8'h24;
  localparam logic [7:0] CH_AMP       = 8'h26;
  localparam logic [7:0] CH_BAR       = 8'h7C;
  localparam logic [7:0] CH_BACKSLASH = 8'h5C;
  localparam logic [7:0] CH_LETTER_A  = 8'h41;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       s_tvalid = 1'b0;
  logic       s_tready;
  logic [7:0] s_tdata = 8'h00;
  logic       m_tvalid;
  logic       m_tready = 1'b0;
  logic [7:0] m_tdata;
  logic [1:0] m_tuser;
  logic       m_tlast;

  int   errors;
  int   outstanding;
  int   src_idle_pct;
  int   sink_idle_pct = 0;
  logic hold_req = 1'b0;
  int   hold_left = 0;
  int   sent = 0;
  int   quiet_cycles = 0;

  // Extremes, every escape, bad leads and sequences ended by their last byte, a zero or a bad byte
  logic [7:0] opening_text[$] = '{
    8'h01, 8'h1F, 8'h7F, CH_DOLLAR, CH_AMP, CH_BAR, CH_BACKSLASH, CH_LETTER_A,
    8'h80, 8'hFF, 8'h00,
    8'hC3, 8'hA9,             // two-byte sequence
    8'hE2, 8'h82, 8'hAC,      // euro sign
    8'hEF, 8'hBF, 8'hBF,      // plain three-byte sequence
    8'hC3, 8'h00,             // zero while waiting for the final byte
    8'hE2, 8'h82, 8'h00,      // zero while waiting for the third byte
    8'hE2, CH_LETTER_A,       // bad second byte is swallowed
    8'hC3, 8'hC3              // lead where a continuation belongs
  };

  initial begin
    forever #6 clk = ~clk;
  end

  utf8_checked_latex_escaper dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  utf8le_checker u_checker (
    .clk         (clk),
    .rst         (rst),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .s_tdata     (s_tdata),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata),
    .m_tuser     (m_tuser),
    .m_tlast     (m_tlast),
    .errors      (errors),
    .outstanding (outstanding)
  );

  // Receiver: random backpressure, or a counted hold-off when requested
  initial begin
    forever begin
      @(posedge clk);
      if (rst) begin
        m_tready <= 1'b0;
      end else if (hold_req) begin
        hold_left = HOLD_CYCLES;
        m_tready <= 1'b0;
      end else if (hold_left != 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= ($urandom_range(99) >= sink_idle_pct);
      end
    end
  end

  // Watchdog: end the run once nothing has moved for too long
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("utf8_checked_latex_escaper verification failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Offer one byte, idling at random first, and return at its transfer edge
  task automatic send_byte(input logic [7:0] b);
    while ($urandom_range(99) < src_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    sent++;
  endtask

  // Drop valid and wait until every predicted result has been taken
  task automatic drain_results();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  function automatic logic [7:0] rand_cont();
    return 8'h80 | 8'($urandom_range(63));
  endfunction

  // Nonzero byte that cannot continue a sequence
  function automatic logic [7:0] rand_breaker();
    if ($urandom_range(1) == 0)
      return 8'($urandom_range(8'h01, 8'h7F));
    return 8'($urandom_range(8'hC0, 8'hFF));
  endfunction

  // One random token: mostly well-formed text, some noise and broken sequences
  task automatic send_token();
    int pick;
    pick = $urandom_range(99);
    if (pick < 30) begin
      send_byte(8'($urandom_range(8'h20, 8'h7F)));
    end else if (pick < 40) begin
      case ($urandom_range(3))
        0:       send_byte(CH_DOLLAR);
        1:       send_byte(CH_AMP);
        2:       send_byte(CH_BAR);
        default: send_byte(CH_BACKSLASH);
      endcase
    end else if (pick < 45) begin
      send_byte(8'($urandom_range(8'h01, 8'h1F)));
    end else if (pick < 60) begin
      send_byte(8'hC0 | 8'($urandom_range(31)));
      send_byte(rand_cont());
    end else if (pick < 78) begin
      if ($urandom_range(3) == 0) begin
        send_byte(8'hE2);
        send_byte(8'h82);
        send_byte(8'hAC);
      end else begin
        send_byte(8'hE0 | 8'($urandom_range(15)));
        send_byte(rand_cont());
        send_byte(rand_cont());
      end
    end else if (pick < 84) begin
      send_byte(8'($urandom_range(255)));
    end else if (pick < 88) begin
      if ($urandom_range(1) == 0)
        send_byte(8'($urandom_range(8'h80, 8'hBF)));
      else
        send_byte(8'($urandom_range(8'hF0, 8'hFF)));
    end else if (pick < 92) begin
      send_byte(8'h00);
    end else begin
      // Broken sequence: a lead, maybe a good second byte, then a breaker or a zero
      if ($urandom_range(1) == 0) begin
        send_byte(8'hC0 | 8'($urandom_range(31)));
      end else begin
        send_byte(8'hE0 | 8'($urandom_range(15)));
        if ($urandom_range(1) == 0) send_byte(rand_cont());
      end
      if ($urandom_range(2) == 0) send_byte(8'h00);
      else send_byte(rand_breaker());
    end
  endtask

  initial begin
    int step;
    int target;
    src_idle_pct = 0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    for (step = 0; step < 3; step++) begin
      // Sender 30 / receiver 84, then swapped, then no idling at all
      case (step)
        0: begin
          src_idle_pct = 30;
          sink_idle_pct <= 84;
        end
        1: begin
          src_idle_pct = 84;
          sink_idle_pct <= 30;
        end
        default: begin
          src_idle_pct = 0;
          sink_idle_pct <= 0;
        end
      endcase
      target = sent + ITEMS_PER_STEP;

      if (step == 0) begin
        foreach (opening_text[i]) send_byte(opening_text[i]);
      end

      if (step == 2) begin
        // Hold the output off while backslashes and random tokens keep coming: fills the block
        hold_req <= 1'b1;
        @(posedge clk);
        hold_req <= 1'b0;
        repeat (HOLD_BURST) begin
          if ($urandom_range(1) == 0) send_byte(CH_BACKSLASH);
          else send_token();
        end
      end

      while (sent < target) send_token();
      drain_results();
    end

    // Give a stray result time to show up
    repeat (20) @(posedge clk);
    if (errors == 0 && outstanding == 0)
      $display("utf8_checked_latex_escaper verification clean");
    else
      $display("utf8_checked_latex_escaper verification failed");
    $finish;
  end

endmodule
